/* rtl/skt_pkg.sv */
// ----------------------------------------------------------------------------
// Sorted key table package
// Shared types, operation codes and status codes of the sorted key table.
// ----------------------------------------------------------------------------
package skt_pkg;

  localparam int SKT_CAPACITY = 32;

  localparam int KEY_W  = 32;
  localparam int ATTR_W = 16;
  localparam int POS_W  = 6;
  localparam int IDX_W  = 5;
  localparam int FUNC_W = 2;
  localparam int STAT_W = 2;

  // Operation codes.
  localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_FIND   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_READ   = 2'd2;
  localparam logic [FUNC_W-1:0] FUNC_DUMP   = 2'd3;

  // Result status codes.
  localparam logic [STAT_W-1:0] STAT_OK       = 2'd0;
  localparam logic [STAT_W-1:0] STAT_DUP      = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL     = 2'd2;
  localparam logic [STAT_W-1:0] STAT_NOTFOUND = 2'd3;

  typedef struct packed {
    logic [KEY_W-1:0]  key;
    logic              kind;
    logic [ATTR_W-1:0] attr;
  } skt_entry_t;

  // Per-cell control issued by the sequencer.
  typedef struct packed {
    logic cmp_en;
    logic load_new;
    logic shift_in;
  } skt_cell_ctl_t;

endpackage

/* rtl/skt_cell.sv */
// ----------------------------------------------------------------------------
// Sorted key table cell
// Holds one entry, compares it against a search key and takes either a new
// entry or its lower neighbor's entry when an insert opens a slot.
// ----------------------------------------------------------------------------
module skt_cell
  import skt_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  skt_cell_ctl_t ctl,
  input  logic          occ,
  input  logic [KEY_W-1:0] cmp_key,
  input  skt_entry_t    new_ent,
  input  skt_entry_t    left_ent,
  output skt_entry_t    ent,
  output logic          le,
  output logic          eq
);

  skt_entry_t ent_r;
  logic       le_r;
  logic       eq_r;

  always_ff @(posedge clk) begin
    if (ctl.load_new) begin
      ent_r <= new_ent;
    end else if (ctl.shift_in) begin
      ent_r <= left_ent;
    end
  end

  // Compare flags are only meaningful for occupied cells.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      le_r <= 1'b0;
      eq_r <= 1'b0;
    end else if (ctl.cmp_en) begin
      le_r <= occ && (ent_r.key <= cmp_key);
      eq_r <= occ && (ent_r.key == cmp_key);
    end
  end

  assign ent = ent_r;
  assign le  = le_r;
  assign eq  = eq_r;

endmodule

/* rtl/sorted_key_table_unit.sv */
// ----------------------------------------------------------------------------
// Sorted key table unit
// A table of entries kept in ascending key order in a chain of cells.
// ----------------------------------------------------------------------------
// Usage: commands arrive as transfers on the in_ stream; results leave as
// transfers on the out_ stream. Insert, find and read produce exactly one
// result with out_tlast high. Dump produces one result per stored entry in
// ascending key order, out_tlast high on the final one; a dump of an empty
// table produces nothing.
// Timing: a command is taken only while the sequencer is idle. Insert, find
// and read pass through a compare step, in which every cell compares its key
// in parallel and registers its flags, and then a resolve step, which forms
// the result and loads it into the output register; the next command is
// taken only after that. A dump emits its entries in order, one each time
// the output register is free. These steps follow from the compare stage
// of the cell chain and the single output register.
// Stall: while out_tready is low the finished result holds in the output
// register; the next command may still be taken, and it waits in its
// resolve step until the output register is free.
// Reset: rst_n (synchronous, active low) empties the table and drops any
// pending result. No clearing pass is needed; cells beyond the fill count
// are simply ignored.
// ----------------------------------------------------------------------------
module sorted_key_table_unit
  import skt_pkg::*;
#(
  parameter int CAPACITY = SKT_CAPACITY
) (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: func[1:0], part_number[33:2], attribute[49:34], index[54:50]
  input  logic [55:0] in_tdata,
  // in_tuser: kind[0]
  input  logic        in_tuser,
  input  logic        in_tvalid,
  output logic        in_tready,
  // out_tdata: status[1:0], position[7:2], key_out[39:8], attribute_out[55:40]
  output logic [55:0] out_tdata,
  // out_tuser: kind_out[0]
  output logic        out_tuser,
  output logic        out_tlast,
  output logic        out_tvalid,
  input  logic        out_tready
);

  localparam int IDXW = $clog2(CAPACITY);
  localparam int CNTW = $clog2(CAPACITY + 1);

  // Sequencer states.
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_CMP  = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;
  localparam logic [1:0] S_DUMP = 2'd3;

  logic [1:0]        state_r, state_nxt;
  logic [CNTW-1:0]   count_r, count_nxt;
  logic [IDXW-1:0]   dump_idx_r, dump_idx_nxt;

  // Command held for the duration of its execution.
  logic [FUNC_W-1:0] op_func_r;
  logic [KEY_W-1:0]  op_key_r;
  logic              op_kind_r;
  logic [ATTR_W-1:0] op_attr_r;
  logic [IDX_W-1:0]  op_index_r;

  // Output register.
  logic              out_valid_r;
  logic [STAT_W-1:0] res_status_r, res_status_nxt;
  logic [POS_W-1:0]  res_pos_r, res_pos_nxt;
  skt_entry_t        res_ent_r, res_ent_nxt;
  logic              res_last_r, res_last_nxt;

  logic in_xfer;
  logic out_free;
  logic out_ld;
  logic exec_go;
  logic do_ins;
  logic dup;
  logic full;
  logic rd_hit;

  logic [CAPACITY-1:0] occ;
  logic [CAPACITY-1:0] le_v;
  logic [CAPACITY-1:0] eq_v;
  logic [CAPACITY-1:0] ld_v;
  logic [CAPACITY-1:0] sh_v;
  logic [CAPACITY-1:0] sel_v;
  logic [IDXW-1:0]     eq_pos;
  logic [IDXW-1:0]     ld_pos;
  skt_entry_t          sel_ent;
  skt_entry_t          new_ent;
  skt_entry_t          cell_ent  [CAPACITY];
  skt_entry_t          left_ent  [CAPACITY];
  skt_cell_ctl_t       cell_ctl  [CAPACITY];

  logic [6:0]          cnt7;
  logic [CNTW+6:0]     cnt_ext;
  logic [6:0]          idx7;

  // Zero-extend or truncate a count-wide value to the 6-bit position field.
  function automatic logic [POS_W-1:0] to_pos(input logic [CNTW-1:0] v);
    logic [CNTW+POS_W-1:0] t;
    t = {{POS_W{1'b0}}, v};
    return t[POS_W-1:0];
  endfunction

  assign in_xfer  = in_tvalid && in_tready;
  assign in_tready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_tready;
  assign exec_go  = (state_r == S_EXEC) && out_free;

  assign new_ent.key  = op_key_r;
  assign new_ent.kind = op_kind_r;
  assign new_ent.attr = op_attr_r;

  assign cnt_ext = {7'd0, count_r};
  assign cnt7    = cnt_ext[6:0];
  assign idx7    = {2'd0, op_index_r};

  // ---------------------------------------------------------------------------
  // Cell chain. Each cell compares its key with the command key; on insert
  // the cells above the insertion point take their lower neighbor's entry.
  // ---------------------------------------------------------------------------
  assign left_ent[0] = new_ent;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    if (g > 0) begin : g_left
      assign left_ent[g] = cell_ent[g-1];
    end

    skt_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (cell_ctl[g]),
      .occ      (occ[g]),
      .cmp_key  (op_key_r),
      .new_ent  (new_ent),
      .left_ent (left_ent[g]),
      .ent      (cell_ent[g]),
      .le       (le_v[g]),
      .eq       (eq_v[g])
    );
  end

  // Occupancy, insertion point, shift enables and selection one-hot.
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      occ[i] = (CNTW'(i) < count_r);
      if (i == 0) begin
        ld_v[i] = !le_v[i];
        sh_v[i] = 1'b0;
      end else begin
        ld_v[i] = le_v[i-1] && !le_v[i];
        sh_v[i] = occ[i-1] && !le_v[i-1];
      end
      if (state_r == S_DUMP) begin
        sel_v[i] = (IDXW'(i) == dump_idx_r);
      end else if (op_func_r == FUNC_READ) begin
        sel_v[i] = occ[i] && (7'(i) == idx7);
      end else begin
        sel_v[i] = eq_v[i];
      end
    end
  end

  // One-hot to binary for the match and the insertion slot, and the
  // AND-OR read mux over the cells.
  always_comb begin
    eq_pos  = '0;
    ld_pos  = '0;
    sel_ent = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (eq_v[i]) begin
        eq_pos = eq_pos | IDXW'(i);
      end
      if (ld_v[i]) begin
        ld_pos = ld_pos | IDXW'(i);
      end
      if (sel_v[i]) begin
        sel_ent = sel_ent | cell_ent[i];
      end
    end
  end

  assign dup    = |eq_v;
  assign full   = (count_r == CNTW'(CAPACITY));
  assign do_ins = (op_func_r == FUNC_INSERT) && !dup && !full;
  assign rd_hit = (idx7 < cnt7);

  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      cell_ctl[i].cmp_en   = (state_r == S_CMP);
      cell_ctl[i].load_new = exec_go && do_ins && ld_v[i];
      cell_ctl[i].shift_in = exec_go && do_ins && sh_v[i];
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer and result formation.
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    dump_idx_nxt   = dump_idx_r;
    out_ld         = 1'b0;
    res_status_nxt = STAT_OK;
    res_pos_nxt    = '0;
    res_ent_nxt    = '0;
    res_last_nxt   = 1'b1;

    unique case (state_r)
      S_IDLE: begin
        if (in_xfer) begin
          if (in_tdata[1:0] == FUNC_DUMP) begin
            dump_idx_nxt = '0;
            if (count_r != '0) begin
              state_nxt = S_DUMP;
            end
          end else begin
            state_nxt = S_CMP;
          end
        end
      end
      S_CMP: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (out_free) begin
          out_ld    = 1'b1;
          state_nxt = S_IDLE;
          unique case (op_func_r)
            FUNC_INSERT: begin
              if (dup) begin
                res_status_nxt = STAT_DUP;
                res_pos_nxt    = to_pos(CNTW'(eq_pos));
                res_ent_nxt    = sel_ent;
              end else if (full) begin
                res_status_nxt = STAT_FULL;
                res_pos_nxt    = to_pos(count_r);
              end else begin
                res_status_nxt = STAT_OK;
                res_pos_nxt    = to_pos(CNTW'(ld_pos));
                res_ent_nxt    = new_ent;
                count_nxt      = count_r + 1'b1;
              end
            end
            FUNC_FIND: begin
              if (dup) begin
                res_status_nxt = STAT_OK;
                res_pos_nxt    = to_pos(CNTW'(eq_pos));
                res_ent_nxt    = sel_ent;
              end else begin
                res_status_nxt = STAT_NOTFOUND;
                res_pos_nxt    = to_pos(count_r);
              end
            end
            FUNC_READ: begin
              res_pos_nxt = {1'b0, op_index_r};
              if (rd_hit) begin
                res_status_nxt = STAT_OK;
                res_ent_nxt    = sel_ent;
              end else begin
                res_status_nxt = STAT_NOTFOUND;
              end
            end
            default: begin
              // A dump never reaches this state.
              out_ld = 1'b0;
            end
          endcase
        end
      end
      S_DUMP: begin
        if (out_free) begin
          out_ld       = 1'b1;
          res_status_nxt = STAT_OK;
          res_pos_nxt  = to_pos(CNTW'(dump_idx_r));
          res_ent_nxt  = sel_ent;
          res_last_nxt = (CNTW'(dump_idx_r) + 1'b1 == count_r);
          dump_idx_nxt = dump_idx_r + 1'b1;
          if (res_last_nxt) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      dump_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      dump_idx_r <= dump_idx_nxt;
      if (out_ld) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Command capture.
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      op_func_r  <= in_tdata[1:0];
      op_key_r   <= in_tdata[33:2];
      op_attr_r  <= in_tdata[49:34];
      op_index_r <= in_tdata[54:50];
      op_kind_r  <= in_tuser;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (out_ld) begin
      res_status_r <= res_status_nxt;
      res_pos_r    <= res_pos_nxt;
      res_ent_r    <= res_ent_nxt;
      res_last_r   <= res_last_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {res_ent_r.attr, res_ent_r.key, res_pos_r, res_status_r};
  assign out_tuser  = res_ent_r.kind;
  assign out_tlast  = res_last_r;

endmodule
